### rtl/tsgc_pkg.sv
// tsgc_pkg: shared codes, widths and types of the touch swipe gesture classifier
// no dependencies; imported by every module of the block
package tsgc_pkg;

  // event kinds
  localparam logic [1:0] EV_PRESS    = 2'd0;
  localparam logic [1:0] EV_PRESSING = 2'd1;
  localparam logic [1:0] EV_RELEASE  = 2'd2;

  // swipe directions
  localparam logic [2:0] MV_NONE  = 3'd0;
  localparam logic [2:0] MV_UP    = 3'd1;
  localparam logic [2:0] MV_DOWN  = 3'd2;
  localparam logic [2:0] MV_LEFT  = 3'd3;
  localparam logic [2:0] MV_RIGHT = 3'd4;

  // register indexes (byte address 4*index)
  localparam logic [2:0] REG_VEDGE  = 3'd0;
  localparam logic [2:0] REG_HEDGE  = 3'd1;
  localparam logic [2:0] REG_VMOVE  = 3'd2;
  localparam logic [2:0] REG_HMOVE  = 3'd3;
  localparam logic [2:0] REG_TAN    = 3'd4;
  localparam logic [2:0] REG_SLOW   = 3'd5;
  localparam logic [2:0] REG_SHORT  = 3'd6;

  // square root unit: radicand is d2 * 2^16, root is floor(256 * sqrt(d2))
  localparam int SQ_IN_W  = 38;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_OUT_W + 3;

  // multiplier operand and product widths
  localparam int MUL_W  = 16;
  localparam int PROD_W = 2 * MUL_W;

  typedef struct packed {
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sq_res_t;

endpackage

### rtl/tsgc_mul.sv
// tsgc_mul: shared 16x16 unsigned multiplier with registered product
// depends on tsgc_pkg
module tsgc_mul (
  input  logic                         clk,
  input  logic [tsgc_pkg::MUL_W-1:0]   a,
  input  logic [tsgc_pkg::MUL_W-1:0]   b,
  output logic [tsgc_pkg::PROD_W-1:0]  prod
);
  import tsgc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### rtl/tsgc_sqrt.sv
// tsgc_sqrt: digit-by-digit integer square root, two radicand bits per cycle
// depends on tsgc_pkg
module tsgc_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tsgc_pkg::SQ_IN_W-1:0]  radicand,
  output tsgc_pkg::sq_res_t             res
);
  import tsgc_pkg::*;

  localparam int CNT_W = $clog2(SQ_OUT_W + 1);

  logic [SQ_IN_W-1:0]  rad;
  logic [SQ_REM_W-1:0] rem;
  logic [SQ_OUT_W-1:0] root;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;
  logic                fits;

  always_comb begin
    rem_sh = {rem[SQ_REM_W-3:0], rad[SQ_IN_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SQ_OUT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[SQ_IN_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[SQ_OUT_W-2:0], fits};
    end
  end

  assign res.done = done;
  assign res.root = root;

endmodule

### rtl/touch_swipe_gesture_classifier_unit.sv
// touch_swipe_gesture_classifier_unit: top level of the swipe gesture classifier
// depends on tsgc_pkg, tsgc_mul, tsgc_sqrt
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+--------------------------------------
//   input    | in_valid / in_stall          | touched, touch_x, touch_y, now_ms
//   output   | out_valid / out_stall        | event_kind .. is_slow, one beat max
//   config   | apb psel/penable/pwrite      | paddr[4:2] index, pwdata, prdata
//
// an untouched sample with no gesture gives no beat
// a press goes from S_EVAL straight to S_OUT; pressing or release
// runs four passes through the shared multiplier and 19 root steps
// one sample in flight at a time; the next sample is taken while a finished
// beat still waits in the output register
// a stalled beat keeps the sequencer in its last state until the beat drains
// rst is synchronous and clears config to defaults and all gesture state
module touch_swipe_gesture_classifier_unit #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst,
  // sample input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        touched,
  input  logic [9:0]  touch_x,
  input  logic [9:0]  touch_y,
  input  logic [31:0] now_ms,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [9:0]  start_x,
  output logic [9:0]  start_y,
  output logic [9:0]  stop_x,
  output logic [9:0]  stop_y,
  output logic [3:0]  start_zone,
  output logic [3:0]  stop_zone,
  output logic [2:0]  direction,
  output logic [15:0] hold_ms,
  output logic [10:0] travel_px,
  output logic        is_short,
  output logic        is_slow,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsgc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_MX, S_MY, S_MP, S_MT, S_TA, S_SQ, S_OUT
  } state_t;

  // config registers
  logic [9:0]  vedge, hedge, vmove, hmove;
  logic [13:0] tan_q8;
  logic [15:0] slow_q8, short_ms;

  // gesture state
  logic        active;
  logic [9:0]  start_px, start_py, last_px, last_py;
  logic [3:0]  start_edges;
  logic [31:0] press_time;
  logic [2:0]  held_dir;
  logic [10:0] held_dist;
  logic [1:0]  held_flags;   // bit0 short, bit1 slow

  // per-sample work registers
  state_t      state;
  logic        s_tv;
  logic [9:0]  s_x, s_y;
  logic [31:0] s_now;
  logic [1:0]  kind;
  logic [15:0] dur;
  logic [20:0] d2;
  logic [31:0] p_reg;
  logic [23:0] ta_reg;

  logic        wr_en;
  logic        tv;
  logic [31:0] elapsed;
  logic signed [10:0] dx, dy;
  logic [10:0] ndx, ndy;
  logic [9:0]  adx, ady;
  logic        moved, vert, slow;
  logic [2:0]  dir_new;
  logic        out_load;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic               sq_start;
  logic [SQ_IN_W-1:0] sq_rad;
  sq_res_t            sq_res;

  // edge area bits: top, bottom, left, right
  function automatic logic [3:0] edge_bits(input logic [9:0] px, input logic [9:0] py);
    logic signed [11:0] hy;
    logic signed [11:0] wx;
    logic [3:0]         a;
    hy   = 12'(SCREEN_HEIGHT) - {2'b00, py};
    wx   = 12'(SCREEN_WIDTH) - {2'b00, px};
    a[0] = py < vedge;
    a[1] = hy < $signed({2'b00, vedge});
    a[2] = px < hedge;
    a[3] = wx < $signed({2'b00, hedge});
    return a;
  endfunction

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      vedge    <= 10'd20;
      hedge    <= 10'd20;
      vmove    <= 10'd50;
      hmove    <= 10'd50;
      tan_q8   <= 14'd256;
      slow_q8  <= 16'd256;
      short_ms <= 16'd300;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_VEDGE: vedge    <= pwdata[9:0];
        REG_HEDGE: hedge    <= pwdata[9:0];
        REG_VMOVE: vmove    <= pwdata[9:0];
        REG_HMOVE: hmove    <= pwdata[9:0];
        REG_TAN:   tan_q8   <= pwdata[13:0];
        REG_SLOW:  slow_q8  <= pwdata[15:0];
        REG_SHORT: short_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_VEDGE: prdata = {22'd0, vedge};
      REG_HEDGE: prdata = {22'd0, hedge};
      REG_VMOVE: prdata = {22'd0, vmove};
      REG_HMOVE: prdata = {22'd0, hmove};
      REG_TAN:   prdata = {18'd0, tan_q8};
      REG_SLOW:  prdata = {16'd0, slow_q8};
      REG_SHORT: prdata = {16'd0, short_ms};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  // a touch outside the screen counts as untouched
  assign tv = touched && ({1'b0, touch_x} < 11'(SCREEN_WIDTH))
                      && ({1'b0, touch_y} < 11'(SCREEN_HEIGHT));

  assign in_stall = (state != S_IDLE);
  assign elapsed  = s_now - press_time;

  // signed travel from start to the latest valid point
  always_comb begin
    dx    = $signed({1'b0, last_px}) - $signed({1'b0, start_px});
    dy    = $signed({1'b0, last_py}) - $signed({1'b0, start_py});
    ndx   = 11'(-dx);
    ndy   = 11'(-dy);
    adx   = dx[10] ? ndx[9:0] : dx[9:0];
    ady   = dy[10] ? ndy[9:0] : dy[9:0];
    moved = (dx != 11'sd0) || (dy != 11'sd0);
    vert  = (dx == 11'sd0) || ({6'd0, ady, 8'd0} > ta_reg);
    // p > floor(sqrt(d2 * 2^16)) is the same as p^2 > d2 * 2^16
    slow  = (dur != 16'd0) && (p_reg > {{(32-SQ_OUT_W){1'b0}}, sq_res.root});
    dir_new = held_dir;
    if (vert) begin
      if (ady > vmove) dir_new = dy[10] ? MV_UP : MV_DOWN;
    end else begin
      if (adx > hmove) dir_new = dx[10] ? MV_LEFT : MV_RIGHT;
    end
  end

  // shared multiplier schedule: adx^2, ady^2, slow*dur, tan*adx
  always_comb begin
    unique case (state)
      S_MX:    begin mul_a = 16'(adx);   mul_b = 16'(adx); end
      S_MY:    begin mul_a = 16'(ady);   mul_b = 16'(ady); end
      S_MP:    begin mul_a = slow_q8;    mul_b = dur;      end
      S_MT:    begin mul_a = 16'(tan_q8); mul_b = 16'(adx); end
      default: begin mul_a = '0;         mul_b = '0;       end
    endcase
  end

  tsgc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // root of d2 scaled by 2^16 serves both the distance and the slow test
  assign sq_start = (state == S_MT);
  assign sq_rad   = {1'b0, d2, 16'd0};

  tsgc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .res      (sq_res)
  );

  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active      <= 1'b0;
      start_px    <= '0;
      start_py    <= '0;
      last_px     <= '0;
      last_py     <= '0;
      start_edges <= '0;
      press_time  <= '0;
      held_dir    <= MV_NONE;
      held_dist   <= '0;
      held_flags  <= '0;
      out_valid   <= 1'b0;
    end else begin
      // a taken beat frees the output register unless a new one loads
      if (!out_load && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            s_tv  <= tv;
            s_x   <= touch_x;
            s_y   <= touch_y;
            s_now <= now_ms;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (s_tv) begin
            last_px <= s_x;
            last_py <= s_y;
          end
          priority if (!active && !s_tv) begin
            state <= S_IDLE;
          end else if (!active) begin
            active      <= 1'b1;
            press_time  <= s_now;
            start_px    <= s_x;
            start_py    <= s_y;
            start_edges <= edge_bits(s_x, s_y);
            kind        <= EV_PRESS;
            dur         <= '0;
            state       <= S_OUT;
          end else begin
            kind  <= s_tv ? EV_PRESSING : EV_RELEASE;
            dur   <= (|elapsed[31:16]) ? 16'hFFFF : elapsed[15:0];
            state <= S_MX;
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          d2    <= prod[20:0];
          state <= S_MP;
        end
        S_MP: begin
          d2    <= d2 + prod[20:0];
          state <= S_MT;
        end
        S_MT: begin
          p_reg <= prod;
          state <= S_TA;
        end
        S_TA: begin
          ta_reg <= prod[23:0];
          state  <= S_SQ;
        end
        S_SQ: begin
          if (sq_res.done) begin
            held_flags[0] <= dur < short_ms;
            if (moved) begin
              held_dist     <= sq_res.root[SQ_OUT_W-1:8];
              held_flags[1] <= slow;
              held_dir      <= dir_new;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid   <= 1'b1;
            event_kind  <= kind;
            start_x     <= start_px;
            start_y     <= start_py;
            stop_x      <= last_px;
            stop_y      <= last_py;
            start_zone  <= start_edges;
            stop_zone   <= edge_bits(last_px, last_py);
            direction   <= held_dir;
            hold_ms     <= dur;
            travel_px   <= held_dist;
            is_short    <= held_flags[0];
            is_slow     <= held_flags[1];
            // release ends the gesture
            if (kind == EV_RELEASE) begin
              active      <= 1'b0;
              start_px    <= '0;
              start_py    <= '0;
              last_px     <= '0;
              last_py     <= '0;
              start_edges <= '0;
              press_time  <= '0;
              held_dir    <= MV_NONE;
              held_dist   <= '0;
              held_flags  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/tsgc_checker.sv
// tsgc_checker: port-level assertions of the gesture classifier, bound to the top
// depends on tsgc_pkg and touch_swipe_gesture_classifier_unit
module tsgc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  event_kind,
  input logic [2:0]  direction,
  input logic [15:0] hold_ms,
  input logic [10:0] travel_px,
  input logic        is_short,
  input logic        is_slow
);
  import tsgc_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(hold_ms))
    else $error("stalled output beat changed");

  // each accepted sample blocks the input for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // a press carries zero duration and the cleared held values
  a_press_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_PRESS |->
      hold_ms == 16'd0 && direction == MV_NONE && travel_px == 11'd0 && !is_slow)
    else $error("press beat carries held values");

  // no undefined event kind is ever shown
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind == EV_PRESS || event_kind == EV_PRESSING ||
                  event_kind == EV_RELEASE)
    else $error("illegal event kind");

endmodule

bind touch_swipe_gesture_classifier_unit tsgc_checker u_tsgc_checker (.*);

### bench/tb_top.sv
// tb_top: self-checking bench for the touch swipe gesture classifier
// depends on tsgc_pkg and touch_swipe_gesture_classifier_unit; predicts each
// result beat in-bench and checks it against the block under random back-pressure
`timescale 1ns / 1ps

module tb_top;
  import tsgc_pkg::*;

  localparam int SCR_W         = 480;
  localparam int SCR_H         = 480;
  localparam int SETTLE_CYCLES = 40;   // a sample that gives no beat can still be in flight

  // one expected result beat, field order matches the output ports
  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  x0;
    logic [9:0]  y0;
    logic [9:0]  x1;
    logic [9:0]  y1;
    logic [3:0]  area0;
    logic [3:0]  area1;
    logic [2:0]  dir;
    logic [15:0] dur;
    logic [10:0] travel;
    logic        short_f;
    logic        slow_f;
  } gesture_event_t;

  typedef enum int {STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_RUNS, STALL_PERIODIC} stall_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        touched;
  logic [9:0]  touch_x;
  logic [9:0]  touch_y;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [9:0]  start_x;
  logic [9:0]  start_y;
  logic [9:0]  stop_x;
  logic [9:0]  stop_y;
  logic [3:0]  start_zone;
  logic [3:0]  stop_zone;
  logic [2:0]  direction;
  logic [15:0] hold_ms;
  logic [10:0] travel_px;
  logic        is_short;
  logic        is_slow;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  touch_swipe_gesture_classifier_unit #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .touched    (touched),
    .touch_x    (touch_x),
    .touch_y    (touch_y),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .start_x    (start_x),
    .start_y    (start_y),
    .stop_x     (stop_x),
    .stop_y     (stop_y),
    .start_zone (start_zone),
    .stop_zone  (stop_zone),
    .direction  (direction),
    .hold_ms    (hold_ms),
    .travel_px  (travel_px),
    .is_short   (is_short),
    .is_slow    (is_slow),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // ---------------------------------------------------------------------------
  // predictor state: register mirror plus the gesture being tracked
  // ---------------------------------------------------------------------------
  logic [31:0]    cfg_regs [0:6];
  bit             g_active;
  int             g_x0, g_y0, g_x1, g_y1;
  logic [3:0]     g_area0;
  logic [31:0]    g_press_ms;
  logic [2:0]     g_dir;
  logic [10:0]    g_dist;
  bit             g_short, g_slow;

  gesture_event_t events_due[$];     // beats predicted but not yet seen
  int             events_predicted;
  int             mismatch_count;
  int             burst_left;
  logic [31:0]    clock_ms;          // running touch clock for well-formed gestures

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] reg_mask(input logic [2:0] idx);
    case (idx)
      REG_TAN:              return 32'h3FFF;
      REG_SLOW, REG_SHORT:  return 32'hFFFF;
      default:              return 32'h03FF;
    endcase
  endfunction

  // edge area bits; bottom/right use a signed distance to the far border
  function automatic logic [3:0] border_bits(input int x, input int y);
    logic [3:0] a;
    a = '0;
    if (y < int'(cfg_regs[REG_VEDGE]))          a[0] = 1'b1;
    if (SCR_H - y < int'(cfg_regs[REG_VEDGE]))  a[1] = 1'b1;
    if (x < int'(cfg_regs[REG_HEDGE]))          a[2] = 1'b1;
    if (SCR_W - x < int'(cfg_regs[REG_HEDGE]))  a[3] = 1'b1;
    return a;
  endfunction

  // floor of the square root, built one result bit at a time
  function automatic int unsigned floor_root(input longint v);
    int unsigned r, t;
    r = 0;
    for (int b = 10; b >= 0; b--) begin
      t = r | (1 << b);
      if (longint'(t) * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic clear_gesture();
    g_active   = 0;
    g_x0       = 0;
    g_y0       = 0;
    g_x1       = 0;
    g_y1       = 0;
    g_area0    = '0;
    g_press_ms = '0;
    g_dir      = MV_NONE;
    g_dist     = '0;
    g_short    = 0;
    g_slow     = 0;
  endtask

  // advances the tracked gesture by one accepted sample, queues the beat it gives
  task automatic classify_touch(input logic t, input logic [9:0] x, input logic [9:0] y,
                                input logic [31:0] now_val);
    gesture_event_t ev;
    bit             on_screen;
    int             dx, dy;
    longint         adx, ady, d2;
    logic [31:0]    elapsed;
    logic [15:0]    dur;
    logic [63:0]    speed_span, scaled_d2;
    on_screen = t && (x < SCR_W) && (y < SCR_H);
    if (on_screen) begin
      g_x1 = x;
      g_y1 = y;
    end
    if (!g_active && !on_screen) return;
    dur = '0;
    if (!g_active) begin
      g_active   = 1;
      g_press_ms = now_val;
      g_x0       = g_x1;
      g_y0       = g_y1;
      g_area0    = border_bits(g_x0, g_y0);
      ev.kind    = EV_PRESS;
    end else begin
      elapsed = now_val - g_press_ms;
      dur     = (elapsed > 32'd65535) ? 16'hFFFF : elapsed[15:0];
      g_short = (dur < cfg_regs[REG_SHORT][15:0]);
      ev.kind = on_screen ? EV_PRESSING : EV_RELEASE;
      dx  = g_x1 - g_x0;
      dy  = g_y1 - g_y0;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      // a point that has not moved keeps distance, slow flag and direction
      if (dx != 0 || dy != 0) begin
        d2     = adx * adx + ady * ady;
        g_dist = 11'(floor_root(d2));
        g_slow = 0;
        if (dur != 0) begin
          speed_span = 64'(cfg_regs[REG_SLOW][15:0]) * 64'(dur);
          scaled_d2  = 64'(d2) << 16;
          g_slow     = (scaled_d2 < speed_span * speed_span);
        end
        if (dx == 0 || ady * 256 > longint'(cfg_regs[REG_TAN]) * adx) begin
          if (dy > int'(cfg_regs[REG_VMOVE]))       g_dir = MV_DOWN;
          else if (dy < -int'(cfg_regs[REG_VMOVE])) g_dir = MV_UP;
        end else begin
          if (dx > int'(cfg_regs[REG_HMOVE]))       g_dir = MV_RIGHT;
          else if (dx < -int'(cfg_regs[REG_HMOVE])) g_dir = MV_LEFT;
        end
      end
    end
    ev.x0      = 10'(g_x0);
    ev.y0      = 10'(g_y0);
    ev.x1      = 10'(g_x1);
    ev.y1      = 10'(g_y1);
    ev.area0   = g_area0;
    ev.area1   = border_bits(g_x1, g_y1);
    ev.dir     = g_dir;
    ev.dur     = dur;
    ev.travel  = g_dist;
    ev.short_f = g_short;
    ev.slow_f  = g_slow;
    events_due.push_back(ev);
    events_predicted++;
    if (ev.kind == EV_RELEASE) clear_gesture();
  endtask

  task automatic compare_field(input string name, input longint want, input longint seen);
    if (want != seen) begin
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, seen);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern and beat checker
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_OFF;
  int          mode_left  = 0;
  int          run_left   = 0;
  bit          run_hold   = 0;
  int          stall_tick = 0;

  // the stall pattern is picked anew at random from time to time, no-stall stretches included
  always @(negedge clk) begin
    bit hold;
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 4));
      mode_left  = $urandom_range(50, 400);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      STALL_LIGHT: hold = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: hold = ($urandom_range(0, 3) != 0);
      STALL_RUNS: begin
        if (run_left == 0) begin
          run_hold = !run_hold;
          run_left = run_hold ? $urandom_range(1, 40) : $urandom_range(1, 12);
        end
        run_left--;
        hold = run_hold;
      end
      STALL_PERIODIC: hold = (stall_tick % 3 == 0);
      default: hold = 0;
    endcase
    out_stall <= hold;
  end

  always @(posedge clk) begin : beat_check
    gesture_event_t want, seen;
    if (!rst && out_valid && !out_stall) begin
      seen = {event_kind, start_x, start_y, stop_x, stop_y, start_zone, stop_zone,
              direction, hold_ms, travel_px, is_short, is_slow};
      if (events_due.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none got kind %0d", $time, event_kind);
        mismatch_count++;
      end else begin
        want = events_due.pop_front();
        compare_field("event_kind",  want.kind,    seen.kind);
        compare_field("start_x",     want.x0,      seen.x0);
        compare_field("start_y",     want.y0,      seen.y0);
        compare_field("stop_x",      want.x1,      seen.x1);
        compare_field("stop_y",      want.y1,      seen.y1);
        compare_field("start_zone",  want.area0,   seen.area0);
        compare_field("stop_zone",   want.area1,   seen.area1);
        compare_field("direction",   want.dir,     seen.dir);
        compare_field("hold_ms",     want.dur,     seen.dur);
        compare_field("travel_px",   want.travel,  seen.travel);
        compare_field("is_short",    want.short_f, seen.short_f);
        compare_field("is_slow",     want.slow_f,  seen.slow_f);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample side
  // ---------------------------------------------------------------------------

  // drives one sample at the falling edge and holds it until the block accepts it
  task automatic send_sample(input logic t, input int x, input int y, input logic [31:0] now_val);
    @(negedge clk);
    in_valid <= 1'b1;
    touched  <= t;
    touch_x  <= 10'(x);
    touch_y  <= 10'(y);
    now_ms   <= now_val;
    do @(posedge clk); while (in_stall);
    classify_touch(t, 10'(x), 10'(y), now_val);
  endtask

  // bursts of random length, gaps of random length between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    case ($urandom_range(0, 9))
      0, 1, 2:       gap = 0;
      3, 4, 5, 6, 7: gap = $urandom_range(1, 4);
      default:       gap = $urandom_range(5, 45);
    endcase
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic play(input logic t, input int x, input int y, input logic [31:0] now_val);
    send_sample(t, x, y, now_val);
    pace();
  endtask

  // sender holds off until every predicted beat has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  task automatic reg_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    for (int i = REG_VEDGE; i <= REG_SHORT; i++) begin
      reg_access(1'b0, 3'(i), '0, rd);
      compare_field($sformatf("register %0d readback", i), cfg_regs[i], rd);
    end
  endtask

  // registers change only once nothing is in flight
  task automatic apply_setting(input logic [31:0] vals [0:6]);
    logic [31:0] rd;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = REG_VEDGE; i <= REG_SHORT; i++) begin
      reg_access(1'b1, 3'(i), vals[i], rd);
      cfg_regs[i] = vals[i] & reg_mask(3'(i));
    end
    check_regs();
  endtask

  task automatic random_setting();
    logic [31:0] v [0:6];
    v[REG_VEDGE] = $urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(1, 1023);
    v[REG_HEDGE] = $urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(1, 1023);
    v[REG_VMOVE] = $urandom_range(0, 1) ? $urandom_range(1, 150) : $urandom_range(1, 1023);
    v[REG_HMOVE] = $urandom_range(0, 1) ? $urandom_range(1, 150) : $urandom_range(1, 1023);
    v[REG_TAN]   = $urandom_range(0, 1) ? $urandom_range(1, 1024) : $urandom_range(1, 14668);
    v[REG_SLOW]  = $urandom_range(0, 1) ? $urandom_range(1, 2048) : $urandom_range(1, 65535);
    v[REG_SHORT] = $urandom_range(0, 1) ? $urandom_range(1, 1000) : $urandom_range(1, 65535);
    apply_setting(v);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic
  // ---------------------------------------------------------------------------

  // start points lean toward the borders so the edge bits all get exercised
  function automatic int pick_coord(input int span);
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 30);
      1:       return span - 1 - $urandom_range(0, 30);
      default: return $urandom_range(0, span - 1);
    endcase
  endfunction

  function automatic logic [31:0] step_ms();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return $urandom_range(60000, 200000);   // long hold, duration can saturate
      2:       return $urandom;                        // wild jump, clock wraps
      3, 4:    return $urandom_range(100, 3000);
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  function automatic int clamp_span(input int v, input int span);
    if (v < 0) return 0;
    if (v >= span) return span - 1;
    return v;
  endfunction

  // press, a few moves, then release or a slide off the screen
  task automatic play_gesture();
    int sx, sy, px, py, steps, reach;
    sx = pick_coord(SCR_W);
    sy = pick_coord(SCR_H);
    clock_ms += step_ms();
    play(1'b1, sx, sy, clock_ms);
    steps = $urandom_range(0, 7);
    for (int i = 0; i < steps; i++) begin
      clock_ms += step_ms();
      case ($urandom_range(0, 6))
        0: begin px = sx; py = sy; end                             // back at the start
        1: reach = 8;
        2: reach = 80;
        3: begin px = sx; py = $urandom_range(0, SCR_H - 1); end   // pure vertical
        4: begin px = $urandom_range(0, SCR_W - 1); py = sy; end   // pure horizontal
        default: reach = 400;
      endcase
      if (reach > 0) begin
        px = clamp_span(sx + $urandom_range(0, 2 * reach) - reach, SCR_W);
        py = clamp_span(sy + $urandom_range(0, 2 * reach) - reach, SCR_H);
      end
      reach = 0;
      play(1'b1, px, py, clock_ms);
    end
    clock_ms += step_ms();
    case ($urandom_range(0, 5))
      0:       play(1'b1, $urandom_range(SCR_W, 1023), $urandom_range(0, 1023), clock_ms);
      1:       play(1'b1, $urandom_range(0, 1023), $urandom_range(SCR_H, 1023), clock_ms);
      default: play(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023), clock_ms);
    endcase
  endtask

  // idle chatter, off-screen touches and fully random samples
  task automatic play_noise();
    int n;
    case ($urandom_range(0, 3))
      0: play(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      1: play(1'b1, $urandom_range(SCR_W, 1023), $urandom_range(0, 1023), $urandom);
      2: play(1'b1, $urandom_range(0, 1023), $urandom_range(SCR_H, 1023), $urandom);
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) play(1'($urandom), $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      end
    endcase
    clock_ms = $urandom_range(0, 1) ? clock_ms : $urandom;
  endtask

  // keeps playing until the requested number of beats has been predicted
  task automatic run_traffic(input int beats);
    int goal, played;
    goal   = events_predicted + beats;
    played = 0;
    while (events_predicted < goal) begin
      if ($urandom_range(0, 6) == 0) play_noise();
      else play_gesture();
      played++;
      if (played % 50 == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_register_reset();
    check_regs();
  endtask

  task automatic test_directed_cases();
    play(1'b0, 1023, 1023, 32'h0000_0000);     // idle and untouched: no beat
    play(1'b1, 480, 5, 32'h0000_0001);         // touch just off the right border: no beat
    play(1'b1, 0, 0, 32'hFFFF_FFF0);           // press in the top-left corner
    play(1'b1, 0, 0, 32'h0000_0005);           // clock wraps, no movement
    play(1'b1, 479, 479, 32'h0000_0010);       // full diagonal, bottom-right corner
    play(1'b1, 0, 479, 32'h0000_0010);         // dx zero counts as vertical
    play(1'b1, 10, 400, 32'h0000_0012);
    play(1'b0, 0, 0, 32'h0000_0010 + 32'd70000);   // release after a saturated hold
    play(1'b1, 479, 0, 32'hFFFF_FFFF);         // press top-right at the clock's top
    play(1'b1, 479, 200, 32'h7FFF_FFFF);
    play(1'b1, 1023, 1023, 32'h8000_0000);     // slide off screen ends the gesture
    play(1'b1, 240, 240, 32'd100);             // press mid-screen
    play(1'b1, 240, 240, 32'd100);             // zero duration, no movement
    play(1'b1, 300, 240, 32'd100);             // zero duration with movement is fast
    play(1'b1, 240, 100, 32'd101);             // swipe up
    play(1'b1, 241, 240, 32'd4000);            // tiny move, slow, direction held
    play(1'b1, 200, 250, 32'd4001);            // below the horizontal threshold
    play(1'b0, 10'h2AA, 10'h155, 32'd4002);    // release
    play(1'b1, 20, 19, 32'd5000);              // press on the edge boundary
    play(1'b0, 10'h155, 10'h2AA, 32'd5000);    // immediate release, zero duration
    drain_results();
  endtask

  task automatic test_register_sweep();
    apply_setting('{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1});
    run_traffic(100);
    apply_setting('{32'd1023, 32'd1023, 32'd1023, 32'd1023, 32'd14668, 32'd65535, 32'd65535});
    run_traffic(100);
    random_setting();
    run_traffic(100);
    random_setting();
    run_traffic(100);
    apply_setting('{32'd20, 32'd20, 32'd50, 32'd50, 32'd256, 32'd256, 32'd300});
  endtask

  task automatic test_random_gestures(input int beats);
    run_traffic(beats / 2);
    random_setting();
    run_traffic(beats - beats / 2);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    touched    = 1'b0;
    touch_x    = '0;
    touch_y    = '0;
    now_ms     = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    mismatch_count   = 0;
    events_predicted = 0;
    burst_left       = 0;
    clock_ms         = $urandom;
    cfg_regs[REG_VEDGE] = 32'd20;
    cfg_regs[REG_HEDGE] = 32'd20;
    cfg_regs[REG_VMOVE] = 32'd50;
    cfg_regs[REG_HMOVE] = 32'd50;
    cfg_regs[REG_TAN]   = 32'd256;
    cfg_regs[REG_SLOW]  = 32'd256;
    cfg_regs[REG_SHORT] = 32'd300;
    clear_gesture();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_directed_cases();
    test_register_sweep();
    test_random_gestures(1250);

    // let the last beats out, then wait for anything unexpected
    drain_results();
    repeat (SETTLE_CYCLES + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
